// ----- hdl/cdd_pkg.sv -----
package cdd_pkg;

    // Microprogram counter.
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    // Datapath operation selected by the control word.
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_MULQ,
        OP_SETQR,
        OP_NORM,
        OP_DAY,
        OP_MONTH,
        OP_YEARS,
        OP_UNDER,
        OP_OUT
    } op_t;

    // Jump condition. When the condition is false the counter holds.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_DISPATCH,
        C_LOOP_END,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic accept;
        logic out_free;
        logic loop_end;
        upc_t disp_target;
    } status_t;

    // Microprogram addresses.
    localparam upc_t UA_IDLE  = 4'd0;
    localparam upc_t UA_MULQ  = 4'd1;
    localparam upc_t UA_SETQR = 4'd2;
    localparam upc_t UA_NORM  = 4'd3;
    localparam upc_t UA_DAY   = 4'd4;
    localparam upc_t UA_MONTH = 4'd5;
    localparam upc_t UA_YEARS = 4'd6;
    localparam upc_t UA_UNDER = 4'd7;
    localparam upc_t UA_OUT   = 4'd8;

    // Mode codes.
    localparam logic [2:0] MODE_DAYS      = 3'd0;
    localparam logic [2:0] MODE_WEEKS     = 3'd1;
    localparam logic [2:0] MODE_MONTHS    = 3'd2;
    localparam logic [2:0] MODE_YEARS     = 3'd3;
    localparam logic [2:0] MODE_DECADES   = 3'd4;
    localparam logic [2:0] MODE_CENTURIES = 3'd5;
    localparam logic [2:0] MODE_MILLENNIA = 3'd6;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Year / 100 by reciprocal: floor(y * 5243 / 2^19) is exact for y below 2^14.
    localparam int         RECIP_SHIFT = 19;
    localparam int         P_W         = 27;
    localparam int         Q_W         = 8;
    localparam logic [12:0] RECIP100   = 13'd5243;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m < MON_JAN || m > MON_DEC) begin
            len = 5'd31;
        end else if (m == MON_FEB && leap) begin
            len = 5'd29;
        end else begin
            len = MONTH_LEN[m - 4'd1];
        end
        return len;
    endfunction

    // The microprogram.
    function automatic uword_t urom(input upc_t addr);
        uword_t w;
        case (addr)
            UA_IDLE:  w = '{op: OP_LOAD,  cond: C_ACCEPT,   target: UA_MULQ};
            UA_MULQ:  w = '{op: OP_MULQ,  cond: C_ALWAYS,   target: UA_SETQR};
            UA_SETQR: w = '{op: OP_SETQR, cond: C_ALWAYS,   target: UA_NORM};
            UA_NORM:  w = '{op: OP_NORM,  cond: C_DISPATCH, target: UA_IDLE};
            UA_DAY:   w = '{op: OP_DAY,   cond: C_LOOP_END, target: UA_OUT};
            UA_MONTH: w = '{op: OP_MONTH, cond: C_LOOP_END, target: UA_OUT};
            UA_YEARS: w = '{op: OP_YEARS, cond: C_ALWAYS,   target: UA_OUT};
            UA_UNDER: w = '{op: OP_UNDER, cond: C_ALWAYS,   target: UA_OUT};
            UA_OUT:   w = '{op: OP_OUT,   cond: C_OUT_FREE, target: UA_IDLE};
            default:  w = '{op: OP_LOAD,  cond: C_ALWAYS,   target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/cdd_seq.sv -----
module cdd_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  cdd_pkg::status_t stat,
    output cdd_pkg::uword_t  uword
);
    import cdd_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;

    assign uword = urom(upc_reg);

    // A false condition holds the counter on the current step.
    always_comb begin
        case (uword.cond)
            C_ALWAYS:   upc_next = uword.target;
            C_ACCEPT:   upc_next = stat.accept   ? uword.target : upc_reg;
            C_DISPATCH: upc_next = stat.disp_target;
            C_LOOP_END: upc_next = stat.loop_end ? uword.target : upc_reg;
            C_OUT_FREE: upc_next = stat.out_free ? uword.target : upc_reg;
            default:    upc_next = UA_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- hdl/calendar_date_decrement_unit.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_mode, s_year, s_month, s_day, s_amount
// m_       out        m_valid / m_ready  m_new_year, m_new_month, m_new_day, m_underflow
//
// One item at a time. Setup runs through load, year/100 multiply, remainder, and normalize
// and dispatch; the transfer into the output register follows. Day and week modes step back
// one day per loop step and month mode one month per step, until the amount is spent or
// the floor date is reached; year-type modes subtract the whole span at once. The day loop is the slowest.
// Reset is synchronous and active low; it returns the sequencer to idle and empties the output
// register. A stalled result waits there while the next item is accepted and worked on.
module calendar_date_decrement_unit #(
    parameter int unsigned MAX_AMOUNT = 1023
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [13:0] s_year,
    input  logic [3:0]  s_month,
    input  logic [4:0]  s_day,
    input  logic [9:0]  s_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_new_year,
    output logic [3:0]  m_new_month,
    output logic [4:0]  m_new_day,
    output logic        m_underflow
);
    import cdd_pkg::*;

    // The amount port is 10 bits wide, so the useful clamp never exceeds 1023.
    localparam int AMT_MAX = (MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023;
    localparam int AMT_W   = $clog2(AMT_MAX + 1);
    localparam int CNT_W   = $clog2(AMT_MAX * 7 + 1);
    localparam int DEC_W   = $clog2(AMT_MAX * 1000 + 1);
    localparam int CMP_W   = (DEC_W > 14) ? DEC_W : 14;

    uword_t  uword;
    status_t stat;

    cdd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .uword   (uword)
    );

    // Working registers of the datapath.
    logic [2:0]       mode_reg,  mode_next;
    logic [13:0]      y_reg,     y_next;
    logic [3:0]       m_reg,     m_next;
    logic [4:0]       d_reg,     d_next;
    logic [AMT_W-1:0] n_reg,     n_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DEC_W-1:0] dec_reg,   dec_next;
    logic [P_W-1:0]   p_reg,     p_next;
    logic [Q_W-1:0]   q_reg,     q_next;
    logic [6:0]       r_reg,     r_next;
    logic             under_reg, under_next;

    // Output register.
    logic             ov_reg, ov_next;
    logic [13:0]      oy_reg, oy_next;
    logic [3:0]       om_reg, om_next;
    logic [4:0]       od_reg, od_next;
    logic             ou_reg, ou_next;

    logic             leap;
    logic [4:0]       dim_cur;
    logic [4:0]       dim_prev;
    logic             cnt_zero;
    logic             floor_day;
    logic             floor_month;
    logic             out_free;
    logic [Q_W-1:0]   q_calc;
    int unsigned      unit;

    // The year is tracked together with its quotient and remainder by 100, so the
    // leap test needs no divider as the year steps down.
    assign leap     = (y_reg[1:0] == 2'b00) && ((r_reg != 7'd0) || (q_reg[1:0] == 2'b00));
    assign dim_cur  = days_in(m_reg, leap);
    assign dim_prev = days_in(m_reg - 4'd1, leap);
    assign cnt_zero = (cnt_reg == '0);
    assign floor_day   = (d_reg == 5'd1) && (m_reg == MON_JAN) && (y_reg == 14'd1);
    assign floor_month = (m_reg == MON_JAN) && (y_reg == 14'd1);
    assign out_free = !ov_reg || m_ready;
    assign q_calc   = p_reg[RECIP_SHIFT +: Q_W];

    assign s_ready = (uword.op == OP_LOAD);

    always_comb begin
        case (mode_reg)
            MODE_DECADES:   unit = 10;
            MODE_CENTURIES: unit = 100;
            MODE_MILLENNIA: unit = 1000;
            default:        unit = 1;
        endcase
    end

    // Status back to the sequencer.
    always_comb begin
        stat.accept   = s_valid;
        stat.out_free = out_free;
        stat.loop_end = cnt_zero || ((uword.op == OP_DAY) ? floor_day : floor_month);
        if (y_reg == 14'd0) begin
            stat.disp_target = UA_UNDER;
        end else begin
            case (mode_reg)
                MODE_DAYS, MODE_WEEKS: stat.disp_target = UA_DAY;
                MODE_MONTHS:           stat.disp_target = UA_MONTH;
                MODE_YEARS, MODE_DECADES, MODE_CENTURIES, MODE_MILLENNIA: begin
                    stat.disp_target = UA_YEARS;
                end
                default:               stat.disp_target = UA_OUT;
            endcase
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        dec_next   = dec_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        under_next = under_reg;
        ov_next    = ov_reg;
        oy_next    = oy_reg;
        om_next    = om_reg;
        od_next    = od_reg;
        ou_next    = ou_reg;

        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end

        case (uword.op)
            OP_LOAD: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    y_next     = s_year;
                    under_next = 1'b0;
                    if (s_month < MON_JAN) begin
                        m_next = MON_JAN;
                    end else if (s_month > MON_DEC) begin
                        m_next = MON_DEC;
                    end else begin
                        m_next = s_month;
                    end
                    d_next = (s_day == 5'd0) ? 5'd1 : s_day;
                    if (17'(s_amount) > 17'(MAX_AMOUNT)) begin
                        n_next = AMT_W'(MAX_AMOUNT);
                    end else begin
                        n_next = AMT_W'(s_amount);
                    end
                end
            end
            OP_MULQ: begin
                p_next = P_W'(P_W'(y_reg) * P_W'(RECIP100));
            end
            OP_SETQR: begin
                q_next = q_calc;
                r_next = 7'(y_reg - 14'(16'(q_calc) * 16'd100));
            end
            OP_NORM: begin
                if (d_reg > dim_cur) begin
                    d_next = dim_cur;
                end
                if (mode_reg == MODE_WEEKS) begin
                    cnt_next = CNT_W'(32'(n_reg) * 32'd7);
                end else begin
                    cnt_next = CNT_W'(n_reg);
                end
                dec_next = DEC_W'(32'(n_reg) * unit);
            end
            OP_DAY: begin
                if (!cnt_zero) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (d_reg > 5'd1) begin
                        d_next = d_reg - 5'd1;
                    end else if (m_reg > MON_JAN) begin
                        m_next = m_reg - 4'd1;
                        d_next = dim_prev;
                    end else if (y_reg > 14'd1) begin
                        y_next = y_reg - 14'd1;
                        m_next = MON_DEC;
                        d_next = 5'd31;
                        if (r_reg == 7'd0) begin
                            r_next = 7'd99;
                            q_next = q_reg - Q_W'(1);
                        end else begin
                            r_next = r_reg - 7'd1;
                        end
                    end else begin
                        under_next = 1'b1;
                    end
                end
            end
            OP_MONTH: begin
                if (!cnt_zero) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (m_reg > MON_JAN) begin
                        m_next = m_reg - 4'd1;
                        if (d_reg > dim_prev) begin
                            d_next = dim_prev;
                        end
                    end else if (y_reg > 14'd1) begin
                        // December always has 31 days, so no clamp is needed here.
                        y_next = y_reg - 14'd1;
                        m_next = MON_DEC;
                        if (r_reg == 7'd0) begin
                            r_next = 7'd99;
                            q_next = q_reg - Q_W'(1);
                        end else begin
                            r_next = r_reg - 7'd1;
                        end
                    end else begin
                        under_next = 1'b1;
                    end
                end
            end
            OP_YEARS: begin
                if (CMP_W'(dec_reg) >= CMP_W'(y_reg)) begin
                    under_next = 1'b1;
                end else begin
                    y_next = 14'(CMP_W'(y_reg) - CMP_W'(dec_reg));
                end
            end
            OP_UNDER: begin
                under_next = 1'b1;
            end
            OP_OUT: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    ou_next = under_reg;
                    oy_next = under_reg ? 14'd1 : y_reg;
                    om_next = under_reg ? MON_JAN : m_reg;
                    od_next = under_reg ? 5'd1 : d_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg    <= 1'b0;
            under_reg <= 1'b0;
        end else begin
            ov_reg    <= ov_next;
            under_reg <= under_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        y_reg    <= y_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        dec_reg  <= dec_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        oy_reg   <= oy_next;
        om_reg   <= om_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
    end

    assign m_valid     = ov_reg;
    assign m_new_year  = oy_reg;
    assign m_new_month = om_reg;
    assign m_new_day   = od_reg;
    assign m_underflow = ou_reg;

endmodule

// ----- bench/cdd_checker.sv -----
`timescale 1ns / 100ps

module cdd_checker #(
    parameter int unsigned MAX_AMOUNT = 1023
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [13:0] s_year,
    input  logic [3:0]  s_month,
    input  logic [4:0]  s_day,
    input  logic [9:0]  s_amount,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [13:0] m_new_year,
    input  logic [3:0]  m_new_month,
    input  logic [4:0]  m_new_day,
    input  logic        m_underflow,
    output int unsigned fail_count,
    output int unsigned open_count
);
    import cdd_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    // Request fields are kept with the predicted date so that a mismatch can be traced.
    typedef struct packed {
        logic [2:0]  mode;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [9:0]  amount;
        logic [13:0] new_year;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic        underflow;
    } earlier_date_t;

    earlier_date_t earlier_dates[$];

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            2:             len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    function automatic earlier_date_t step_back_date(
        input logic [2:0]  mode,
        input logic [13:0] year,
        input logic [3:0]  month,
        input logic [4:0]  day,
        input logic [9:0]  amount
    );
        earlier_date_t r;
        int unsigned   y, m, d, n, steps, i, span;
        bit            under;
        y = 32'(year);
        m = 32'(month);
        d = 32'(day);
        n = 32'(amount);
        under = 1'b0;
        if (n > MAX_AMOUNT) begin
            n = MAX_AMOUNT;
        end
        if (m < 1) begin
            m = 1;
        end
        if (m > 12) begin
            m = 12;
        end
        if (d < 1) begin
            d = 1;
        end
        if (d > month_days(m, y)) begin
            d = month_days(m, y);
        end

        if (y == 0) begin
            under = 1'b1;
        end else if (mode == MODE_DAYS || mode == MODE_WEEKS) begin
            steps = (mode == MODE_WEEKS) ? n * 7 : n;
            i = 0;
            while (i < steps && !under) begin
                if (d > 1) begin
                    d = d - 1;
                end else if (m > 1) begin
                    m = m - 1;
                    d = month_days(m, y);
                end else if (y > 1) begin
                    y = y - 1;
                    m = 12;
                    d = 31;
                end else begin
                    under = 1'b1;
                end
                i++;
            end
        end else if (mode == MODE_MONTHS) begin
            // The day is clamped after every step, so a long run can only shrink it.
            i = 0;
            while (i < n && !under) begin
                if (m > 1) begin
                    m = m - 1;
                end else if (y > 1) begin
                    y = y - 1;
                    m = 12;
                end else begin
                    under = 1'b1;
                end
                if (!under && d > month_days(m, y)) begin
                    d = month_days(m, y);
                end
                i++;
            end
        end else if (mode == MODE_YEARS || mode == MODE_DECADES ||
                     mode == MODE_CENTURIES || mode == MODE_MILLENNIA) begin
            case (mode)
                MODE_YEARS:     span = 1;
                MODE_DECADES:   span = 10;
                MODE_CENTURIES: span = 100;
                default:        span = 1000;
            endcase
            if (n * span >= y) begin
                under = 1'b1;
            end else begin
                y = y - n * span;
            end
        end

        if (under) begin
            y = 1;
            m = 1;
            d = 1;
        end
        r.mode      = mode;
        r.year      = year;
        r.month     = month;
        r.day       = day;
        r.amount    = amount;
        r.new_year  = y[13:0];
        r.new_month = m[3:0];
        r.new_day   = d[4:0];
        r.underflow = under;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        open_count = 0;
    end

    always @(posedge aclk) begin
        earlier_date_t want;
        if (aresetn) begin
            // A result can never belong to a request taken at the same edge, so pop first.
            if (m_valid && m_ready) begin
                if (earlier_dates.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result %0d-%0d-%0d underflow %0d",
                                 $realtime, m_new_year, m_new_month, m_new_day, m_underflow);
                    end
                end else begin
                    want = earlier_dates.pop_front();
                    if (m_new_year !== want.new_year || m_new_month !== want.new_month ||
                        m_new_day !== want.new_day || m_underflow !== want.underflow) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mode %0d from %0d-%0d-%0d by %0d:",
                                     $realtime, want.mode, want.year, want.month, want.day,
                                     want.amount,
                                     " expected %0d-%0d-%0d uf %0d,",
                                     want.new_year, want.new_month, want.new_day,
                                     want.underflow,
                                     " got %0d-%0d-%0d uf %0d",
                                     m_new_year, m_new_month, m_new_day, m_underflow);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                earlier_dates.push_back(step_back_date(s_mode, s_year, s_month, s_day,
                                                       s_amount));
            end
        end
        open_count <= earlier_dates.size();
    end

endmodule

// ----- bench/tb_calendar_date_decrement_unit.sv -----
`timescale 1ns / 100ps

module tb_calendar_date_decrement_unit;
    import cdd_pkg::*;

    localparam int unsigned MAX_AMOUNT   = 1023;
    // Mode code that the block leaves unused; it must return the normalized start date.
    localparam logic [2:0]  MODE_NONE    = 3'd7;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 76;
    localparam int unsigned PHASES       = 4;
    localparam int unsigned MAX_IDLE     = 14;
    // Settle time after the last transfer, covering setup and the output register.
    localparam int unsigned SETTLE_CYCLES = 20;
    // The slowest legal run is about 100 requests with full stalls; the limit, given in
    // nanoseconds, leaves ample margin.
    localparam longint unsigned RUN_LIMIT_NS = 64'd8_000_000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode      = MODE_DAYS;
    logic [13:0] s_year      = '0;
    logic [3:0]  s_month     = '0;
    logic [4:0]  s_day       = '0;
    logic [9:0]  s_amount    = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [13:0] m_new_year;
    logic [3:0]  m_new_month;
    logic [4:0]  m_new_day;
    logic        m_underflow;

    int unsigned fail_count;
    int unsigned open_count;

    // Idle insertion on each side can be switched off so that some phases run back to back.
    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;

    // The clock has a 2 ns period: one nanosecond high, one low.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    calendar_date_decrement_unit #(
        .MAX_AMOUNT (MAX_AMOUNT)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_year      (s_year),
        .s_month     (s_month),
        .s_day       (s_day),
        .s_amount    (s_amount),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_year  (m_new_year),
        .m_new_month (m_new_month),
        .m_new_day   (m_new_day),
        .m_underflow (m_underflow)
    );

    // The checker watches both channels, predicts every result and counts failures.
    cdd_checker #(
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_year      (s_year),
        .s_month     (s_month),
        .s_day       (s_day),
        .s_amount    (s_amount),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_year  (m_new_year),
        .m_new_month (m_new_month),
        .m_new_day   (m_new_day),
        .m_underflow (m_underflow),
        .fail_count  (fail_count),
        .open_count  (open_count)
    );

    // Offers one request and returns at the edge where its transfer takes place.
    // When no gap is drawn, valid stays high and the new payload follows the last transfer
    // directly, so valid is never lowered and raised within one time step.
    // Handshake signals are read right after the edge, before any update of that edge lands.
    task automatic send_date(
        input logic [2:0]  mode,
        input logic [13:0] year,
        input logic [3:0]  month,
        input logic [4:0]  day,
        input logic [9:0]  amount
    );
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_year   <= year;
        s_month  <= month;
        s_day    <= day;
        s_amount <= amount;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds the sender off until every predicted result has been seen. The first edge lets
    // the checker's count catch up with a transfer that happened at the calling edge.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_count != 0);
    endtask

    // Result side: before each transfer the receiver may hold ready low for a random
    // number of cycles, which lands the stall on any step of the block's sequencer.
    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = sink_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned k;
        logic [2:0]  mode;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [9:0]  amount;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: calendar borrows, leap rules, clamping, saturation and the
        // normalization of out-of-range fields.
        send_date(MODE_DAYS,      14'd2024, 4'd3,    5'd15, 10'd0);    // amount zero
        send_date(MODE_DAYS,      14'd2024, 4'd3,    5'd1,  10'd1);    // into 29 February
        send_date(MODE_DAYS,      14'd1900, 4'd3,    5'd1,  10'd1);    // century, not leap
        send_date(MODE_DAYS,      14'd2000, 4'd3,    5'd1,  10'd1);    // 400-year leap
        send_date(MODE_DAYS,      14'd2023, MON_JAN, 5'd1,  10'd1);    // year borrow
        send_date(MODE_DAYS,      14'd1,    MON_JAN, 5'd1,  10'd1);    // falls before year 1
        send_date(MODE_DAYS,      14'd2,    MON_JAN, 5'd5,  10'd1023); // underflow mid-loop
        send_date(MODE_WEEKS,     14'd9999, MON_DEC, 5'd31, 10'd1023); // longest request
        send_date(MODE_WEEKS,     14'd2024, 4'd3,    5'd3,  10'd1);
        send_date(MODE_MONTHS,    14'd2023, 4'd3,    5'd31, 10'd1);    // clamp to 28
        send_date(MODE_MONTHS,    14'd2024, 4'd5,    5'd31, 10'd3);    // clamping builds up
        send_date(MODE_MONTHS,    14'd1,    MON_DEC, 5'd15, 10'd13);   // month underflow
        send_date(MODE_MONTHS,    14'd9999, MON_JAN, 5'd31, 10'd1023);
        send_date(MODE_YEARS,     14'd2024, MON_FEB, 5'd29, 10'd1);    // 29 February kept
        send_date(MODE_DECADES,   14'd2024, 4'd6,    5'd10, 10'd5);
        send_date(MODE_CENTURIES, 14'd2000, 4'd7,    5'd4,  10'd20);   // lands on year 0
        send_date(MODE_MILLENNIA, 14'd9999, MON_DEC, 5'd31, 10'd1);
        send_date(MODE_MILLENNIA, 14'd16383, 4'd15,  5'd31, 10'd1023); // every bit set
        send_date(MODE_DAYS,      14'd0,    4'd6,    5'd10, 10'd5);    // year zero
        send_date(MODE_NONE,      14'd2024, 4'd0,    5'd0,  10'd100);  // unused mode
        send_date(MODE_MONTHS,    14'd2023, 4'd4,    5'd31, 10'd0);    // day past month end
        send_date(MODE_DAYS,      14'd2023, 4'd13,   5'd31, 10'd0);    // month above 12
        send_date(MODE_DAYS,      14'd16383, MON_JAN, 5'd20, 10'd40);  // year above 9999
        send_date(MODE_YEARS,     14'd5,    4'd8,    5'd8,  10'd5);    // exactly to year 0

        // Pressure point: nothing more is offered until every result is back.
        drain_results();

        // Random requests in four phases: idle on both sides, sender only, receiver only,
        // and none at all. The pipeline drains between phases.
        for (phase = 0; phase < PHASES; phase++) begin
            src_idle_en  = (phase == 0) || (phase == 1);
            sink_idle_en = (phase == 0) || (phase == 2);
            for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
                mode = 3'($urandom_range(0, 7));
                // A quarter of the requests start near year 1 so that saturation is reached.
                year = 14'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 16383));
                month = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 12));
                day = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 31));
                // Day and week requests step back one day at a time, so large amounts stay rare.
                if (mode == MODE_DAYS || mode == MODE_WEEKS) begin
                    amount = 10'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                              : $urandom_range(0, 60));
                end else begin
                    amount = 10'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023)
                                                             : $urandom_range(0, 20));
                end
                send_date(mode, year, month, day, amount);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
